// ===== src/qz_pkg.sv =====
// Octree color quantizer package: sizes, codes, node row layout and word types.
// Used by every module of the quantizer but qz_ram; depends on nothing.
package qz_pkg;

   localparam int POOL      = 4096;
   localparam int NODE_W    = $clog2(POOL);
   localparam int LINK_W    = NODE_W + 1;
   localparam int MAX_DEPTH = 8;
   localparam int LVL_W     = 4;
   localparam int SUM_W     = 32;
   localparam int CNT_W     = $clog2(SUM_W);
   localparam int WALK_N    = MAX_DEPTH + 1;
   localparam int LEAF_W    = NODE_W + 1;

   localparam logic [LINK_W-1:0] NIL = LINK_W'(POOL);

   localparam logic [1:0] KIND_ADD   = 2'd0;
   localparam logic [1:0] KIND_READ  = 2'd1;
   localparam logic [1:0] KIND_CLEAR = 2'd2;

   localparam logic [2:0] ADDR_MAX_COLORS = 3'd0;
   localparam logic [2:0] ADDR_COLOR_BITS = 3'd4;

   localparam logic [8:0] MAX_COLORS_RST = 9'd256;
   localparam logic [3:0] COLOR_BITS_RST = 4'd8;

   typedef struct packed {
      logic                         leaf;
      logic [SUM_W-1:0]             count;
      logic [SUM_W-1:0]             rsum;
      logic [SUM_W-1:0]             gsum;
      logic [SUM_W-1:0]             bsum;
      logic [LINK_W-1:0]            next;
      logic [7:0][LINK_W-1:0]       link;
   } node_row_type;

   localparam int ROW_W = $bits(node_row_type);

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] red_in;
      logic [7:0] green_in;
      logic [7:0] blue_in;
   } req_word_type;

   typedef struct packed {
      logic       entry_valid;
      logic [7:0] palette_index;
      logic [7:0] red_avg;
      logic [7:0] green_avg;
      logic [7:0] blue_avg;
      logic       last_entry;
   } rsp_word_type;

   typedef struct packed {
      logic [8:0] max_colors;
      logic [3:0] color_bits;
   } csr_type;

   typedef struct packed {
      logic         valid;
      rsp_word_type word;
   } result_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ADD_ROOT,
      ST_ADD_RD,
      ST_ADD_VISIT,
      ST_ADD_ALLOC,
      ST_RED_CHK,
      ST_RED_RD,
      ST_RED_CH,
      ST_RED_ACC,
      ST_RED_WR,
      ST_WALK_START,
      ST_WALK_LOOP,
      ST_WALK_RD,
      ST_DIV,
      ST_EMIT
   } state_type;

endpackage

// ===== src/qz_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module qz_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

// ===== src/qz_div.sv =====
// Three-lane restoring divider with a shared divisor, one quotient bit per cycle.
// Depends on qz_pkg.
module qz_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [2:0][qz_pkg::SUM_W-1:0]    num,
   input  logic [qz_pkg::SUM_W-1:0]         den,
   output logic                             done,
   output logic [2:0][7:0]                  quo
);

   logic                                busy_ff, busy_in;
   logic                                done_ff, done_in;
   logic [qz_pkg::CNT_W-1:0]            cnt_ff, cnt_in;
   logic [qz_pkg::SUM_W-1:0]            den_ff, den_in;
   logic [2:0][qz_pkg::SUM_W-1:0]       num_ff, num_in;
   logic [2:0][qz_pkg::SUM_W-1:0]       rem_ff, rem_in;
   logic [2:0][qz_pkg::SUM_W:0]         sh;
   logic [2:0]                          ge;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      den_in  = den_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      for (int i = 0; i < 3; i++) begin
         sh[i] = {rem_ff[i], num_ff[i][qz_pkg::SUM_W-1]};
         ge[i] = sh[i] >= {1'b0, den_ff};
      end
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         den_in  = den;
         num_in  = num;
         rem_in  = '0;
      end else if (busy_ff) begin
         for (int i = 0; i < 3; i++) begin
            rem_in[i] = ge[i] ? qz_pkg::SUM_W'(sh[i] - {1'b0, den_ff})
                              : sh[i][qz_pkg::SUM_W-1:0];
            num_in[i] = {num_ff[i][qz_pkg::SUM_W-2:0], ge[i]};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == qz_pkg::CNT_W'(qz_pkg::SUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      den_ff <= den_in;
      num_ff <= num_in;
      rem_ff <= rem_in;
   end

   assign done = done_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         quo[i] = num_ff[i][7:0];
      end
   end

endmodule

// ===== src/qz_core.sv =====
// Tree engine: sequencer over the node row memory and the free list memory,
// covering pixel insertion, reduction, palette walk and clear. Uses qz_pkg, qz_ram, qz_div.
module qz_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  qz_pkg::req_word_type req_word,
   input  qz_pkg::csr_type      csr,
   input  logic                 slot_free,
   output qz_pkg::result_type   res
);

   qz_pkg::state_type state_ff, state_in;

   qz_pkg::req_word_type      word_ff, word_in;
   logic [qz_pkg::LVL_W-1:0]  level_ff, level_in;
   logic [qz_pkg::NODE_W-1:0] cur_ff, cur_in;
   logic                      alloc_root_ff, alloc_root_in;
   logic                      fsel_ff, fsel_in;
   logic [qz_pkg::NODE_W-1:0] pop_addr_ff, pop_addr_in;
   qz_pkg::node_row_type      row_ff, row_in;
   logic [qz_pkg::LINK_W-1:0] head_ff [8];
   logic [qz_pkg::LINK_W-1:0] head_in [8];
   logic [qz_pkg::LINK_W-1:0] root_ff, root_in;
   logic [qz_pkg::LINK_W-1:0] top_ff, top_in;
   logic [qz_pkg::LINK_W-1:0] lw_ff, lw_in;
   logic [qz_pkg::LEAF_W-1:0] leaf_total_ff, leaf_total_in;
   logic [2:0]                red_lvl_ff, red_lvl_in;
   logic [2:0]                child_ff, child_in;
   logic [3:0]                kids_ff, kids_in;
   logic [qz_pkg::NODE_W-1:0] walk_node_ff [qz_pkg::WALK_N];
   logic [qz_pkg::NODE_W-1:0] walk_node_in [qz_pkg::WALK_N];
   logic [3:0]                walk_child_ff [qz_pkg::WALK_N];
   logic [3:0]                walk_child_in [qz_pkg::WALK_N];
   logic [3:0]                walk_depth_ff, walk_depth_in;
   logic                      started_ff, started_in;
   logic [qz_pkg::LEAF_W-1:0] emitted_ff, emitted_in;
   logic                      emit_ok_ff, emit_ok_in;

   logic                      nm_we;
   logic [qz_pkg::NODE_W-1:0] nm_waddr, nm_raddr;
   qz_pkg::node_row_type      nm_wdata, nm_rdata;
   logic                      fl_we;
   logic [qz_pkg::NODE_W-1:0] fl_waddr, fl_raddr, fl_rdata, fl_wdata;

   logic                      div_start, div_done;
   logic [2:0][qz_pkg::SUM_W-1:0] div_num;
   logic [2:0][7:0]           div_quo;

   logic [3:0]                bits_eff;
   logic [2:0]                bitpos;
   logic [2:0]                idx;
   logic [qz_pkg::LINK_W-1:0] visit_child;
   logic [qz_pkg::LINK_W-1:0] pop_addr;
   logic [qz_pkg::NODE_W-1:0] alloc_n;
   logic [qz_pkg::LVL_W-1:0]  new_lvl;
   logic                      new_leaf;
   logic                      any_head;
   logic [2:0]                deep_lvl;
   logic [qz_pkg::LINK_W-1:0] red_child;
   logic                      over;
   logic [3:0]                wd1;
   logic                      accept;
   logic                      top_empty;
   logic                      lvl_end;
   qz_pkg::node_row_type      fresh;

   qz_ram #(.WIDTH(qz_pkg::ROW_W), .DEPTH(qz_pkg::POOL)) u_node_ram (
      .clock (clock),
      .we    (nm_we),
      .waddr (nm_waddr),
      .wdata (nm_wdata),
      .raddr (nm_raddr),
      .rdata (nm_rdata)
   );

   qz_ram #(.WIDTH(qz_pkg::NODE_W), .DEPTH(qz_pkg::POOL)) u_free_ram (
      .clock (clock),
      .we    (fl_we),
      .waddr (fl_waddr),
      .wdata (fl_wdata),
      .raddr (fl_raddr),
      .rdata (fl_rdata)
   );

   assign div_num = {nm_rdata.bsum, nm_rdata.gsum, nm_rdata.rsum};

   qz_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (nm_rdata.count),
      .done  (div_done),
      .quo   (div_quo)
   );

   // shared decode
   always_comb begin
      if (csr.color_bits == 4'd0) begin
         bits_eff = 4'd1;
      end else if (csr.color_bits > 4'(qz_pkg::MAX_DEPTH)) begin
         bits_eff = 4'(qz_pkg::MAX_DEPTH);
      end else begin
         bits_eff = csr.color_bits;
      end
      bitpos      = 3'd7 - level_ff[2:0];
      idx         = {word_ff.red_in[bitpos], word_ff.green_in[bitpos], word_ff.blue_in[bitpos]};
      visit_child = row_ff.link[idx];
      pop_addr    = top_ff - 1'b1;
      alloc_n     = fsel_ff ? qz_pkg::NODE_W'(qz_pkg::POOL - 1) - pop_addr_ff : fl_rdata;
      new_lvl     = alloc_root_ff ? '0 : level_ff + 1'b1;
      new_leaf    = new_lvl >= bits_eff;
      any_head    = 1'b0;
      deep_lvl    = '0;
      for (int i = 0; i < 8; i++) begin
         if (head_ff[i] != qz_pkg::NIL) begin
            any_head = 1'b1;
            deep_lvl = 3'(i);
         end
      end
      red_child = row_ff.link[child_ff];
      over      = leaf_total_ff > qz_pkg::LEAF_W'(csr.max_colors);
      wd1       = walk_depth_ff - 1'b1;
      accept    = req_valid && (state_ff == qz_pkg::ST_IDLE);
      top_empty = top_ff == '0;
      lvl_end   = level_ff >= qz_pkg::LVL_W'(qz_pkg::MAX_DEPTH);
      fresh     = '0;
      fresh.leaf = new_leaf;
      fresh.next = new_leaf ? qz_pkg::NIL : head_ff[new_lvl[2:0]];
      for (int c = 0; c < 8; c++) begin
         fresh.link[c] = qz_pkg::NIL;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         qz_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_word.kind)
                  qz_pkg::KIND_ADD:  state_in = qz_pkg::ST_ADD_ROOT;
                  qz_pkg::KIND_READ: state_in = qz_pkg::ST_WALK_START;
                  default:           state_in = qz_pkg::ST_IDLE;
               endcase
            end
         end
         qz_pkg::ST_ADD_ROOT: begin
            if (root_ff != qz_pkg::NIL) state_in = qz_pkg::ST_ADD_RD;
            else if (top_empty)         state_in = qz_pkg::ST_RED_CHK;
            else                        state_in = qz_pkg::ST_ADD_ALLOC;
         end
         qz_pkg::ST_ADD_RD:    state_in = qz_pkg::ST_ADD_VISIT;
         qz_pkg::ST_ADD_VISIT: begin
            if (row_ff.leaf || lvl_end)        state_in = qz_pkg::ST_RED_CHK;
            else if (visit_child != qz_pkg::NIL) state_in = qz_pkg::ST_ADD_RD;
            else if (top_empty)                state_in = qz_pkg::ST_RED_CHK;
            else                               state_in = qz_pkg::ST_ADD_ALLOC;
         end
         qz_pkg::ST_ADD_ALLOC: state_in = qz_pkg::ST_ADD_VISIT;
         qz_pkg::ST_RED_CHK: begin
            state_in = (over && any_head) ? qz_pkg::ST_RED_RD : qz_pkg::ST_IDLE;
         end
         qz_pkg::ST_RED_RD: state_in = qz_pkg::ST_RED_CH;
         qz_pkg::ST_RED_CH: begin
            if (red_child != qz_pkg::NIL) state_in = qz_pkg::ST_RED_ACC;
            else if (child_ff == 3'd7)    state_in = qz_pkg::ST_RED_WR;
         end
         qz_pkg::ST_RED_ACC: begin
            state_in = (child_ff == 3'd7) ? qz_pkg::ST_RED_WR : qz_pkg::ST_RED_CH;
         end
         qz_pkg::ST_RED_WR:     state_in = qz_pkg::ST_RED_CHK;
         qz_pkg::ST_WALK_START: state_in = qz_pkg::ST_WALK_LOOP;
         qz_pkg::ST_WALK_LOOP: begin
            state_in = (walk_depth_ff == '0) ? qz_pkg::ST_EMIT : qz_pkg::ST_WALK_RD;
         end
         qz_pkg::ST_WALK_RD: begin
            state_in = nm_rdata.leaf ? qz_pkg::ST_DIV : qz_pkg::ST_WALK_LOOP;
         end
         qz_pkg::ST_DIV: begin
            if (div_done) state_in = qz_pkg::ST_EMIT;
         end
         qz_pkg::ST_EMIT: begin
            if (slot_free) state_in = qz_pkg::ST_IDLE;
         end
         default: state_in = qz_pkg::ST_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      word_in       = word_ff;
      level_in      = level_ff;
      cur_in        = cur_ff;
      alloc_root_in = alloc_root_ff;
      fsel_in       = fsel_ff;
      pop_addr_in   = pop_addr_ff;
      row_in        = row_ff;
      head_in       = head_ff;
      root_in       = root_ff;
      top_in        = top_ff;
      lw_in         = lw_ff;
      leaf_total_in = leaf_total_ff;
      red_lvl_in    = red_lvl_ff;
      child_in      = child_ff;
      kids_in       = kids_ff;
      walk_node_in  = walk_node_ff;
      walk_child_in = walk_child_ff;
      walk_depth_in = walk_depth_ff;
      started_in    = started_ff;
      emitted_in    = emitted_ff;
      emit_ok_in    = emit_ok_ff;
      nm_we         = 1'b0;
      nm_waddr      = cur_ff;
      nm_wdata      = row_ff;
      nm_raddr      = cur_ff;
      fl_we         = 1'b0;
      fl_waddr      = top_ff[qz_pkg::NODE_W-1:0];
      fl_wdata      = red_child[qz_pkg::NODE_W-1:0];
      fl_raddr      = pop_addr[qz_pkg::NODE_W-1:0];
      div_start     = 1'b0;
      res           = '0;

      unique case (state_ff)
         qz_pkg::ST_IDLE: begin
            if (accept) begin
               word_in = req_word;
               if (req_word.kind == qz_pkg::KIND_ADD || req_word.kind == qz_pkg::KIND_CLEAR) begin
                  walk_depth_in = '0;
                  started_in    = 1'b0;
                  emitted_in    = '0;
               end
               if (req_word.kind == qz_pkg::KIND_CLEAR) begin
                  for (int i = 0; i < 8; i++) head_in[i] = qz_pkg::NIL;
                  root_in       = qz_pkg::NIL;
                  top_in        = qz_pkg::LINK_W'(qz_pkg::POOL);
                  lw_in         = qz_pkg::LINK_W'(qz_pkg::POOL);
                  leaf_total_in = '0;
               end
            end
         end
         qz_pkg::ST_ADD_ROOT: begin
            level_in      = '0;
            alloc_root_in = 1'b1;
            if (root_ff != qz_pkg::NIL) begin
               nm_raddr = root_ff[qz_pkg::NODE_W-1:0];
               cur_in   = root_ff[qz_pkg::NODE_W-1:0];
            end else if (!top_empty) begin
               fsel_in     = pop_addr < lw_ff;
               pop_addr_in = pop_addr[qz_pkg::NODE_W-1:0];
               top_in      = pop_addr;
               if (pop_addr < lw_ff) lw_in = pop_addr;
            end
         end
         qz_pkg::ST_ADD_RD: begin
            row_in = nm_rdata;
         end
         qz_pkg::ST_ADD_VISIT: begin
            if (row_ff.leaf) begin
               nm_we          = 1'b1;
               nm_wdata.count = row_ff.count + 1'b1;
               nm_wdata.rsum  = row_ff.rsum + qz_pkg::SUM_W'(word_ff.red_in);
               nm_wdata.gsum  = row_ff.gsum + qz_pkg::SUM_W'(word_ff.green_in);
               nm_wdata.bsum  = row_ff.bsum + qz_pkg::SUM_W'(word_ff.blue_in);
            end else if (!lvl_end) begin
               if (visit_child != qz_pkg::NIL) begin
                  nm_raddr = visit_child[qz_pkg::NODE_W-1:0];
                  cur_in   = visit_child[qz_pkg::NODE_W-1:0];
                  level_in = level_ff + 1'b1;
               end else if (top_empty) begin
                  nm_we = 1'b1;
               end else begin
                  alloc_root_in = 1'b0;
                  fsel_in       = pop_addr < lw_ff;
                  pop_addr_in   = pop_addr[qz_pkg::NODE_W-1:0];
                  top_in        = pop_addr;
                  if (pop_addr < lw_ff) lw_in = pop_addr;
               end
            end
         end
         qz_pkg::ST_ADD_ALLOC: begin
            if (alloc_root_ff) begin
               root_in = qz_pkg::LINK_W'(alloc_n);
            end else begin
               nm_we              = 1'b1;
               nm_wdata.link[idx] = qz_pkg::LINK_W'(alloc_n);
            end
            if (new_leaf) begin
               leaf_total_in = leaf_total_ff + 1'b1;
            end else begin
               head_in[new_lvl[2:0]] = qz_pkg::LINK_W'(alloc_n);
            end
            cur_in   = alloc_n;
            level_in = new_lvl;
            row_in   = fresh;
         end
         qz_pkg::ST_RED_CHK: begin
            nm_raddr   = head_ff[deep_lvl][qz_pkg::NODE_W-1:0];
            cur_in     = head_ff[deep_lvl][qz_pkg::NODE_W-1:0];
            red_lvl_in = deep_lvl;
         end
         qz_pkg::ST_RED_RD: begin
            row_in             = nm_rdata;
            row_in.rsum        = '0;
            row_in.gsum        = '0;
            row_in.bsum        = '0;
            head_in[red_lvl_ff] = nm_rdata.next;
            child_in           = '0;
            kids_in            = '0;
         end
         qz_pkg::ST_RED_CH: begin
            nm_raddr = red_child[qz_pkg::NODE_W-1:0];
            if (red_child != qz_pkg::NIL) begin
               kids_in = kids_ff + 1'b1;
               if (top_ff < qz_pkg::LINK_W'(qz_pkg::POOL)) begin
                  fl_we  = 1'b1;
                  top_in = top_ff + 1'b1;
               end
            end else if (child_ff != 3'd7) begin
               child_in = child_ff + 1'b1;
            end
         end
         qz_pkg::ST_RED_ACC: begin
            row_in.count = row_ff.count + nm_rdata.count;
            row_in.rsum  = row_ff.rsum + nm_rdata.rsum;
            row_in.gsum  = row_ff.gsum + nm_rdata.gsum;
            row_in.bsum  = row_ff.bsum + nm_rdata.bsum;
            child_in     = child_ff + 1'b1;
         end
         qz_pkg::ST_RED_WR: begin
            nm_we         = 1'b1;
            nm_wdata.leaf = 1'b1;
            for (int c = 0; c < 8; c++) nm_wdata.link[c] = qz_pkg::NIL;
            leaf_total_in = leaf_total_ff + 1'b1 - qz_pkg::LEAF_W'(kids_ff);
         end
         qz_pkg::ST_WALK_START: begin
            if (!started_ff) begin
               started_in = 1'b1;
               if (root_ff != qz_pkg::NIL) begin
                  walk_node_in[0]  = root_ff[qz_pkg::NODE_W-1:0];
                  walk_child_in[0] = '0;
                  walk_depth_in    = 4'd1;
               end
            end
         end
         qz_pkg::ST_WALK_LOOP: begin
            nm_raddr   = walk_node_ff[wd1];
            emit_ok_in = 1'b0;
         end
         qz_pkg::ST_WALK_RD: begin
            if (nm_rdata.leaf) begin
               walk_depth_in = wd1;
               row_in        = nm_rdata;
               div_start     = 1'b1;
               emit_ok_in    = 1'b1;
            end else if (walk_child_ff[wd1] >= 4'd8) begin
               walk_depth_in = wd1;
            end else begin
               walk_child_in[wd1] = walk_child_ff[wd1] + 1'b1;
               if (nm_rdata.link[walk_child_ff[wd1][2:0]] != qz_pkg::NIL &&
                   walk_depth_ff < 4'(qz_pkg::WALK_N)) begin
                  walk_node_in[walk_depth_ff]  =
                     nm_rdata.link[walk_child_ff[wd1][2:0]][qz_pkg::NODE_W-1:0];
                  walk_child_in[walk_depth_ff] = '0;
                  walk_depth_in                = walk_depth_ff + 1'b1;
               end
            end
         end
         qz_pkg::ST_DIV: begin
         end
         qz_pkg::ST_EMIT: begin
            if (slot_free) begin
               res.valid = 1'b1;
               if (emit_ok_ff) begin
                  res.word.entry_valid   = 1'b1;
                  res.word.palette_index = emitted_ff[7:0];
                  if (row_ff.count != '0) begin
                     res.word.red_avg   = div_quo[0];
                     res.word.green_avg = div_quo[1];
                     res.word.blue_avg  = div_quo[2];
                  end
                  res.word.last_entry = (emitted_ff + 1'b1) == leaf_total_ff;
                  emitted_in          = emitted_ff + 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign req_ready = state_ff == qz_pkg::ST_IDLE;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= qz_pkg::ST_IDLE;
         for (int i = 0; i < 8; i++) head_ff[i] <= qz_pkg::NIL;
         root_ff       <= qz_pkg::NIL;
         top_ff        <= qz_pkg::LINK_W'(qz_pkg::POOL);
         lw_ff         <= qz_pkg::LINK_W'(qz_pkg::POOL);
         leaf_total_ff <= '0;
         walk_depth_ff <= '0;
         started_ff    <= 1'b0;
         emitted_ff    <= '0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         root_ff       <= root_in;
         top_ff        <= top_in;
         lw_ff         <= lw_in;
         leaf_total_ff <= leaf_total_in;
         walk_depth_ff <= walk_depth_in;
         started_ff    <= started_in;
         emitted_ff    <= emitted_in;
      end
      word_ff       <= word_in;
      level_ff      <= level_in;
      cur_ff        <= cur_in;
      alloc_root_ff <= alloc_root_in;
      fsel_ff       <= fsel_in;
      pop_addr_ff   <= pop_addr_in;
      row_ff        <= row_in;
      red_lvl_ff    <= red_lvl_in;
      child_ff      <= child_in;
      kids_ff       <= kids_in;
      walk_node_ff  <= walk_node_in;
      walk_child_ff <= walk_child_in;
      emit_ok_ff    <= emit_ok_in;
   end

endmodule

// ===== src/octree_color_quantizer.sv =====
// Octree color quantizer top level: register port, result word register, tree engine.
// Depends on qz_pkg and qz_core.
//
// Items are taken one at a time. An add-pixel word runs a root setup, then per tree
// level a node memory read or a node creation followed by the visit, then a reduction
// check, then for each reduction merge one node memory read per child. A palette read
// runs walk steps through the node memory plus the three-lane bit-serial divider; clear
// and unknown kinds are handled in the idle state.
// Clear is immediate: the free list is tracked by a low-water mark, so no sweep is run.
module octree_color_quantizer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  qz_pkg::req_word_type req_word,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output qz_pkg::rsp_word_type rsp_word,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [2:0]           paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready
);

   qz_pkg::csr_type      csr_ff, csr_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   qz_pkg::rsp_word_type rsp_word_ff, rsp_word_in;
   qz_pkg::result_type   res;
   logic                 slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   qz_core u_core (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .csr       (csr_ff),
      .slot_free (slot_free),
      .res       (res)
   );

   always_comb begin
      csr_in = csr_ff;
      if (psel && penable && pwrite) begin
         unique case (paddr[2])
            qz_pkg::ADDR_COLOR_BITS[2]: csr_in.color_bits = pwdata[3:0];
            default:                    csr_in.max_colors = pwdata[8:0];
         endcase
      end
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (res.valid) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = res.word;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      unique case (paddr[2])
         qz_pkg::ADDR_COLOR_BITS[2]: prdata = 32'(csr_ff.color_bits);
         default:                    prdata = 32'(csr_ff.max_colors);
      endcase
   end

   assign pready    = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.max_colors <= qz_pkg::MAX_COLORS_RST;
         csr_ff.color_bits <= qz_pkg::COLOR_BITS_RST;
         rsp_valid_ff      <= 1'b0;
      end else begin
         csr_ff       <= csr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_word_ff <= rsp_word_in;
   end

endmodule

// ===== src/qz_checker.sv =====
// Port-level checks for the octree color quantizer, bound to the top level.
// Depends on qz_pkg and octree_color_quantizer.
module qz_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input qz_pkg::req_word_type req_word,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input qz_pkg::rsp_word_type rsp_word,
   input logic                 psel,
   input logic                 penable,
   input logic                 pwrite,
   input logic [2:0]           paddr,
   input logic [31:0]          pwdata,
   input logic [31:0]          prdata,
   input logic                 pready
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("result word changed while stalled");

   a_read_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_word.kind == qz_pkg::KIND_READ |=> !req_ready)
      else $error("read word did not occupy the engine");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.entry_valid |-> rsp_word.palette_index == '0 &&
      rsp_word.red_avg == '0 && rsp_word.green_avg == '0 &&
      rsp_word.blue_avg == '0 && !rsp_word.last_entry)
      else $error("exhausted result carries data");

   a_pready: assert property (@(posedge clock) disable iff (reset)
      psel |-> pready)
      else $error("register port stalled");

endmodule

bind octree_color_quantizer qz_checker u_qz_checker (.*);
